>>> rtl/co2_frame_check_and_average_assert.svh
// Assertion macros for the frame checker; empty under synthesis.
`ifndef CO2_FRAME_CHECK_AND_AVERAGE_ASSERT_SVH
`define CO2_FRAME_CHECK_AND_AVERAGE_ASSERT_SVH

`ifndef SYNTHESIS
`define CO2FCA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CO2FCA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CO2FCA_ASSERT(label, prop, msg)
`define CO2FCA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/co2fca_pkg.sv
`default_nettype none

package co2fca_pkg;

  localparam int DEFAULT_SAMPLE_SLOTS = 8;

  localparam logic [7:0] HEADER_BYTE0 = 8'hFF;
  localparam logic [7:0] HEADER_BYTE1 = 8'h86;

  localparam int BYTE_POS_W = 4;
  localparam logic [BYTE_POS_W-1:0] FRAME_LAST = BYTE_POS_W'(8);
  localparam logic [BYTE_POS_W-1:0] POS_HEADER1 = BYTE_POS_W'(1);
  localparam logic [BYTE_POS_W-1:0] POS_PPM_HIGH = BYTE_POS_W'(2);
  localparam logic [BYTE_POS_W-1:0] POS_PPM_LOW = BYTE_POS_W'(3);

endpackage

`default_nettype wire

>>> rtl/co2_frame_check_and_average.sv
// Bytes 0 to 7 of a frame are taken back to back while in_ready stays high.
// The ninth byte gives its result once the bit-serial divider has run; a good frame
// first passes ST_RD_OLD and ST_UPDATE to write the ring, a bad one skips them.
// No byte is taken from the ninth until its result transaction completes.
// Synchronous reset clears the byte count, the ring position, the sums and the
// per-slot valid bits, so every slot reads as zero until written.
`default_nettype none

`include "co2_frame_check_and_average_assert.svh"

module co2_frame_check_and_average
  import co2fca_pkg::*;
#(
  parameter int SAMPLE_SLOTS = DEFAULT_SAMPLE_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             frame_ok,
  output logic [15:0]      ppm,
  output logic [15:0]      average_ppm,
  output logic             average_valid,
  output logic [15:0]      oldest_sample
);

  localparam int IDX_W  = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(SAMPLE_SLOTS + 1);
  localparam int SUM_W  = 16 + $clog2(SAMPLE_SLOTS);
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_UPDATE,
    ST_RD_OLDEST,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  logic [BYTE_POS_W-1:0] byte_position;
  logic [7:0]            checksum_sum;
  logic                  header_good;
  logic [7:0]            ppm_high_byte;
  logic [7:0]            ppm_low_byte;

  logic [15:0]           sample_store [SAMPLE_SLOTS];
  logic [SAMPLE_SLOTS-1:0] slot_valid;
  logic [15:0]           rd_data;
  logic                  rd_valid;

  logic [IDX_W-1:0]      write_index;
  logic [SUM_W-1:0]      nonzero_sum;
  logic [CNT_W-1:0]      nonzero_count;

  // divider
  logic [SUM_W-1:0]      dq;
  logic [CNT_W-1:0]      rem;
  logic [STEP_W-1:0]     step;

  logic [BYTE_POS_W-1:0] pos;
  logic                  accept;
  logic                  frame_good;
  logic [15:0]           old_value;
  logic [SUM_W-1:0]      sum_next;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W:0]        rem_shift;
  logic [CNT_W:0]        rem_diff;
  logic                  qbit;
  logic [CNT_W-1:0]      rem_next;
  logic [SUM_W-1:0]      dq_next;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    pos = byte_position;
    if (frame_start || byte_position > FRAME_LAST) begin
      pos = '0;
    end
  end

  assign frame_good = header_good && (rx_byte == 8'(8'd0 - checksum_sum));

  assign old_value = rd_valid ? rd_data : 16'd0;

  always_comb begin
    sum_next   = nonzero_sum;
    count_next = nonzero_count;
    if (old_value != 16'd0) begin
      sum_next   = sum_next - SUM_W'(old_value);
      count_next = count_next - CNT_W'(1);
    end
    if (ppm != 16'd0) begin
      sum_next   = sum_next + SUM_W'(ppm);
      count_next = count_next + CNT_W'(1);
    end
  end

  // one restoring step: remainder stays below a nonzero count
  assign rem_shift = {rem, dq[SUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, nonzero_count};
  assign qbit      = (rem_shift >= {1'b0, nonzero_count});
  assign rem_next  = qbit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
  assign dq_next   = {dq[SUM_W-2:0], qbit};

  always_ff @(posedge clk) begin
    rd_data <= sample_store[write_index];
    if (state == ST_UPDATE) begin
      sample_store[write_index] <= ppm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      byte_position <= '0;
      checksum_sum  <= '0;
      header_good   <= 1'b0;
      ppm_high_byte <= '0;
      ppm_low_byte  <= '0;
      slot_valid    <= '0;
      rd_valid      <= 1'b0;
      write_index   <= '0;
      nonzero_sum   <= '0;
      nonzero_count <= '0;
      out_valid     <= 1'b0;
      step          <= '0;
    end else begin
      rd_valid <= slot_valid[write_index];
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (pos == '0) begin
              header_good   <= (rx_byte == HEADER_BYTE0);
              checksum_sum  <= '0;
              byte_position <= BYTE_POS_W'(1);
            end else if (pos < FRAME_LAST) begin
              if (pos == POS_HEADER1) begin
                header_good <= header_good && (rx_byte == HEADER_BYTE1);
              end
              if (pos == POS_PPM_HIGH) begin
                ppm_high_byte <= rx_byte;
              end
              if (pos == POS_PPM_LOW) begin
                ppm_low_byte <= rx_byte;
              end
              checksum_sum  <= checksum_sum + rx_byte;
              byte_position <= pos + BYTE_POS_W'(1);
            end else begin
              byte_position <= '0;
              frame_ok      <= frame_good;
              ppm           <= frame_good ? {ppm_high_byte, ppm_low_byte} : 16'd0;
              state         <= frame_good ? ST_RD_OLD : ST_RD_OLDEST;
            end
          end
        end
        ST_RD_OLD: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          nonzero_sum             <= sum_next;
          nonzero_count           <= count_next;
          slot_valid[write_index] <= 1'b1;
          if (write_index == IDX_W'(SAMPLE_SLOTS - 1)) begin
            write_index <= '0;
          end else begin
            write_index <= write_index + IDX_W'(1);
          end
          state <= ST_RD_OLDEST;
        end
        ST_RD_OLDEST: begin
          state <= ST_DIV_INIT;
        end
        ST_DIV_INIT: begin
          oldest_sample <= old_value;
          dq            <= nonzero_sum;
          rem           <= '0;
          step          <= '0;
          state         <= ST_DIV;
        end
        ST_DIV: begin
          dq   <= dq_next;
          rem  <= rem_next;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SUM_W - 1)) begin
            average_valid <= (nonzero_count != '0);
            average_ppm   <= (nonzero_count != '0) ? dq_next[15:0] : 16'd0;
            out_valid     <= 1'b1;
            state         <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `CO2FCA_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken while result pending")
  `CO2FCA_ASSERT(a_count_range, nonzero_count <= CNT_W'(SAMPLE_SLOTS), "nonzero count too big")
  `CO2FCA_ASSERT(a_index_range, {1'b0, write_index} < (IDX_W + 1)'(SAMPLE_SLOTS), "index out of ring")
  `CO2FCA_ASSERT(a_avg_flag, out_valid |-> (average_valid == (nonzero_count != '0)), "average flag mismatch")
  `CO2FCA_ASSERT(a_bad_no_ppm, (out_valid && !frame_ok) |-> (ppm == 16'd0), "bad frame carries ppm")

endmodule

`default_nettype wire
